// File: src/pts_pkg.sv
package pts_pkg;

	// input coordinate and fraction widths
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int DIST_W     = 25;

	// coordinate difference and product widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;

	// squared lengths, cross magnitude
	localparam int DB = 2 * COORD_BITS + 1;

	// scaled squared distance fed to the root, and root widths
	localparam int T_W = DB + 2 * FRAC_BITS + 2;
	localparam int XW  = T_W + (T_W % 2);
	localparam int S_W = XW / 2;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// status that travels with each item down the pipeline
	typedef struct packed {
		logic valid;
		logic in_span;
	} meta_t;

endpackage

// File: src/pts_front.sv
module pts_front
	import pts_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_fire,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output meta_t                        meta,
	output logic [DB-1:0]                rem0,
	output logic [T_W-1:0]               word0,
	output logic [DB-1:0]                den
);

	meta_t                    m_s1, m_s2, m_s3, m_s4, m_s5;
	logic signed [DIFF_W-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [PROD_W-1:0] uxx_s2, uyy_s2, vxux_s2, vyuy_s2, uxvy_s2, uyvx_s2;
	logic signed [PROD_W-1:0] vxx_s2, vyy_s2, wxx_s2, wyy_s2;
	logic [DB-1:0]            len2_s3, da_s3, db_s3;
	logic signed [PROD_W-1:0] dot_s3, cross_s3;
	logic [DB-1:0]            cmag_s4, dmin_s4, len2_s4;
	logic                     use_cross_s4;
	logic [DB-1:0]            rem0_s5, den_s5;
	logic [T_W-1:0]           word0_s5;
	logic [2*DB-1:0]          sq;
	logic [2*DB-1:0]          num;
	logic signed [PROD_W-1:0] cneg;
	logic                     span_ok;

	// advance valid bits; the span flag joins at stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_s1 <= '0;
			m_s2 <= '0;
			m_s3 <= '0;
			m_s4 <= '0;
			m_s5 <= '0;
		end else if (en) begin
			m_s1 <= '{valid: in_fire, in_span: 1'b0};
			m_s2 <= m_s1;
			m_s3 <= m_s2;
			m_s4 <= '{valid: m_s3.valid, in_span: span_ok};
			m_s5 <= m_s4;
		end
	end

	// span test on the projection
	assign span_ok = !dot_s3[PROD_W-1] && (dot_s3[DB-1:0] <= len2_s3);
	assign cneg    = -cross_s3;

	// square the cross product and pick the numerator
	assign sq  = cmag_s4 * cmag_s4;
	assign num = use_cross_s4 ? sq : {{DB{1'b0}}, dmin_s4};

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: differences
			ux_s1 <= $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
			uy_s1 <= $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
			vx_s1 <= $signed({px[COORD_BITS-1], px}) - $signed({ax[COORD_BITS-1], ax});
			vy_s1 <= $signed({py[COORD_BITS-1], py}) - $signed({ay[COORD_BITS-1], ay});
			wx_s1 <= $signed({px[COORD_BITS-1], px}) - $signed({bx[COORD_BITS-1], bx});
			wy_s1 <= $signed({py[COORD_BITS-1], py}) - $signed({by[COORD_BITS-1], by});
			// stage 2: products
			uxx_s2  <= ux_s1 * ux_s1;
			uyy_s2  <= uy_s1 * uy_s1;
			vxux_s2 <= vx_s1 * ux_s1;
			vyuy_s2 <= vy_s1 * uy_s1;
			uxvy_s2 <= ux_s1 * vy_s1;
			uyvx_s2 <= uy_s1 * vx_s1;
			vxx_s2  <= vx_s1 * vx_s1;
			vyy_s2  <= vy_s1 * vy_s1;
			wxx_s2  <= wx_s1 * wx_s1;
			wyy_s2  <= wy_s1 * wy_s1;
			// stage 3: sums
			len2_s3  <= DB'(uxx_s2 + uyy_s2);
			dot_s3   <= vxux_s2 + vyuy_s2;
			cross_s3 <= uxvy_s2 - uyvx_s2;
			da_s3    <= DB'(vxx_s2 + vyy_s2);
			db_s3    <= DB'(wxx_s2 + wyy_s2);
			// stage 4: select case
			cmag_s4      <= cross_s3[PROD_W-1] ? cneg[DB-1:0] : cross_s3[DB-1:0];
			dmin_s4      <= (da_s3 < db_s3) ? da_s3 : db_s3;
			len2_s4      <= len2_s3;
			use_cross_s4 <= span_ok && (len2_s3 != '0);
			// stage 5: divider operands
			rem0_s5  <= num[2*DB-1:DB];
			word0_s5 <= {num[DB-1:0], {(2*FRAC_BITS+2){1'b0}}};
			den_s5   <= use_cross_s4 ? len2_s4 : DB'(1);
		end
	end

	assign meta  = m_s5;
	assign rem0  = rem0_s5;
	assign word0 = word0_s5;
	assign den   = den_s5;

endmodule

// File: src/pts_div.sv
module pts_div
	import pts_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  meta_t          meta_in,
	input  logic [DB-1:0]  rem0,
	input  logic [T_W-1:0] word0,
	input  logic [DB-1:0]  den,
	output meta_t          meta_out,
	output logic [T_W-1:0] quot
);

	meta_t          m_s   [T_W];
	logic [DB-1:0]  rem_s [T_W];
	logic [T_W-1:0] w_s   [T_W];
	logic [DB-1:0]  den_s [T_W];

	// one quotient bit per stage: shift in the next numerator bit, subtract if it fits
	for (genvar i = 0; i < T_W; i++) begin : g_stage
		meta_t          mi;
		logic [DB-1:0]  ri;
		logic [T_W-1:0] wi;
		logic [DB-1:0]  di;
		logic [DB:0]    r2;
		logic [DB:0]    diff;
		logic           fit;

		if (i == 0) begin : g_first
			assign mi = meta_in;
			assign ri = rem0;
			assign wi = word0;
			assign di = den;
		end else begin : g_next
			assign mi = m_s[i-1];
			assign ri = rem_s[i-1];
			assign wi = w_s[i-1];
			assign di = den_s[i-1];
		end

		assign r2   = {ri, wi[T_W-1]};
		assign fit  = r2 >= {1'b0, di};
		assign diff = r2 - {1'b0, di};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				m_s[i] <= '0;
			end else if (en) begin
				m_s[i] <= mi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fit ? diff[DB-1:0] : r2[DB-1:0];
				w_s[i]   <= {wi[T_W-2:0], fit};
				den_s[i] <= di;
			end
		end
	end

	assign meta_out = m_s[T_W-1];
	assign quot     = w_s[T_W-1];

endmodule

// File: src/pts_sqrt.sv
module pts_sqrt
	import pts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  meta_t             meta_in,
	input  logic [T_W-1:0]    t_in,
	output meta_t             meta_out,
	output logic [DIST_W-1:0] dist_val
);

	localparam int RW = S_W + 2;

	meta_t             m_s    [S_W];
	logic [RW-1:0]     rem_s  [S_W];
	logic [S_W-1:0]    root_s [S_W];
	logic [XW-1:0]     x_s    [S_W];
	meta_t             m_sf;
	logic [DIST_W-1:0] dist_sf;
	logic [S_W:0]      inc;
	logic [S_W-1:0]    half;

	// two radicand bits per stage, one root bit out
	for (genvar i = 0; i < S_W; i++) begin : g_stage
		meta_t          mi;
		logic [RW-1:0]  ri;
		logic [S_W-1:0] oi;
		logic [XW-1:0]  xi;
		logic [RW-1:0]  cand;
		logic [RW-1:0]  trial;
		logic           fit;

		if (i == 0) begin : g_first
			assign mi = meta_in;
			assign ri = '0;
			assign oi = '0;
			assign xi = XW'(t_in);
		end else begin : g_next
			assign mi = m_s[i-1];
			assign ri = rem_s[i-1];
			assign oi = root_s[i-1];
			assign xi = x_s[i-1];
		end

		assign cand  = {ri[RW-3:0], xi[XW-1:XW-2]};
		assign trial = {oi, 2'b01};
		assign fit   = cand >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				m_s[i] <= '0;
			end else if (en) begin
				m_s[i] <= mi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= fit ? cand - trial : cand;
				root_s[i] <= {oi[S_W-2:0], fit};
				x_s[i]    <= {xi[XW-3:0], 2'b00};
			end
		end
	end

	// round: largest n with (2n-1) no greater than the root, then saturate
	assign inc  = {1'b0, root_s[S_W-1]} + (S_W+1)'(1);
	assign half = inc[S_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_sf <= '0;
		end else if (en) begin
			m_sf <= m_s[S_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_sf <= (half > S_W'(DIST_MAX)) ? DIST_MAX : half[DIST_W-1:0];
		end
	end

	assign meta_out = m_sf;
	assign dist_val = dist_sf;

endmodule

// File: src/point_to_segment_distance.sv
// Distance from a point to a 2D segment, one query per clock cycle. Each
// transfer carries segment endpoints A and B and point P as signed 16-bit
// centimetres; the result gives the Euclidean distance as unsigned fixed
// point with 8 fraction bits, rounded to nearest with ties up, and
// within_span, set when P projects onto AB (a degenerate segment counts as
// within and gives the distance to its single point). The pipeline is 83
// stages deep: five for differences, products, sums, case selection and the
// cross-product square, 51 for the restoring divider (one quotient bit per
// stage), 26 for the square root (one root bit per stage) and one for
// rounding. Results leave in order, one per query. Any stall on the output
// freezes the whole pipeline, so in_ready falls while a result waits.
module point_to_segment_distance
	import pts_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [DIST_W-1:0]            distance,
	output logic                         within_span
);

	logic           en;
	meta_t          m_front, m_div, m_out;
	logic [DB-1:0]  rem0, den;
	logic [T_W-1:0] word0, quot;

	// advance everything unless the result waits
	assign en       = !m_out.valid || out_ready;
	assign in_ready = en;

	pts_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_fire (in_valid && in_ready),
		.ax      (seg_start_x),
		.ay      (seg_start_y),
		.bx      (seg_end_x),
		.by      (seg_end_y),
		.px      (point_x),
		.py      (point_y),
		.meta    (m_front),
		.rem0    (rem0),
		.word0   (word0),
		.den     (den)
	);

	pts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.meta_in  (m_front),
		.rem0     (rem0),
		.word0    (word0),
		.den      (den),
		.meta_out (m_div),
		.quot     (quot)
	);

	pts_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.meta_in  (m_div),
		.t_in     (quot),
		.meta_out (m_out),
		.dist_val (distance)
	);

	assign out_valid   = m_out.valid;
	assign within_span = m_out.in_span;

	// stall only under output backpressure
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// held result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");

	// no transfer in while the pipeline is frozen
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !(in_valid && in_ready))
		else $error("input accepted during stall");

endmodule

// File: dv/pts_checker.sv
module pts_checker
	import pts_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [DIST_W-1:0]            distance,
	input  logic                         within_span,
	output int                           errors,
	output int                           pending,
	output int                           checked
);

	typedef struct packed {
		logic [DIST_W-1:0] dist_val;
		logic              in_span;
	} seg_result_t;

	seg_result_t expected_results[$];

	// round(sqrt(num / den) * 2^FRAC_BITS), one root bit at a time
	function automatic logic [DIST_W-1:0] scaled_root(logic [127:0] num, logic [127:0] den);
		logic [127:0] target;
		logic [127:0] odd;
		logic [DIST_W-1:0] res;
		logic [DIST_W-1:0] cand;
		target = num << (2 * FRAC_BITS + 2);
		res = '0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			cand = res | (DIST_W'(1) << b);
			odd = 2 * 128'(cand) - 1;
			if (odd * odd * den <= target)
				res = cand;
		end
		return res;
	endfunction

	// distance from P to segment AB, with the projection flag
	function automatic seg_result_t segment_distance(
		logic signed [COORD_BITS-1:0] ax, logic signed [COORD_BITS-1:0] ay,
		logic signed [COORD_BITS-1:0] bx, logic signed [COORD_BITS-1:0] by,
		logic signed [COORD_BITS-1:0] px, logic signed [COORD_BITS-1:0] py);
		longint ux, uy, vx, vy, wx, wy, len2, dot, cr, da, db;
		logic [127:0] cb;
		seg_result_t r;
		ux = longint'(bx) - longint'(ax);
		uy = longint'(by) - longint'(ay);
		vx = longint'(px) - longint'(ax);
		vy = longint'(py) - longint'(ay);
		wx = longint'(px) - longint'(bx);
		wy = longint'(py) - longint'(by);
		len2 = ux * ux + uy * uy;
		dot = vx * ux + vy * uy;
		r.in_span = (dot >= 0) && (dot <= len2);
		if (r.in_span && len2 != 0) begin
			cr = ux * vy - uy * vx;
			if (cr < 0)
				cr = -cr;
			cb = 128'(cr);
			r.dist_val = scaled_root(cb * cb, 128'(len2));
		end else begin
			da = vx * vx + vy * vy;
			db = wx * wx + wy * wy;
			r.dist_val = scaled_root(128'(da < db ? da : db), 128'd1);
		end
		return r;
	endfunction

	task automatic report(string what);
		if (errors < 40)
			$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	assign pending = expected_results.size();

	// predict on input transfer, compare on output transfer
	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			errors = 0;
			checked = 0;
			expected_results.delete();
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(segment_distance(seg_start_x, seg_start_y,
					seg_end_x, seg_end_y, point_x, point_y));
			if (out_valid && out_ready) begin
				checked++;
				if (expected_results.size() == 0) begin
					report("result with nothing outstanding");
				end else begin
					want = expected_results.pop_front();
					if (distance !== want.dist_val)
						report($sformatf("distance %0d, want %0d", distance, want.dist_val));
					if (within_span !== want.in_span)
						report($sformatf("within_span %0b, want %0b", within_span,
							want.in_span));
				end
			end
		end
	end

endmodule

// File: dv/tb_point_to_segment_distance.sv
module tb_point_to_segment_distance;
	import pts_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic signed [COORD_BITS-1:0] seg_start_x = '0, seg_start_y = '0;
	logic signed [COORD_BITS-1:0] seg_end_x = '0, seg_end_y = '0;
	logic signed [COORD_BITS-1:0] point_x = '0, point_y = '0;
	logic in_ready, out_valid, within_span;
	logic [DIST_W-1:0] distance;
	int errors, pending, checked;
	int cycles = 0;
	int sent = 0;
	logic quiet = 1'b0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	always #1 clk = ~clk;

	point_to_segment_distance uut (.*);

	pts_checker checker_i (.*);

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off, none at the end
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				stall_left <= $urandom_range(1, 5);
		end
	end

	// offer one query, at times after a short random idle gap, and hold it until transferred
	task automatic send_query(int ax, int ay, int bx, int by, int px, int py);
		logic ok;
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		seg_start_x <= COORD_BITS'(ax);
		seg_start_y <= COORD_BITS'(ay);
		seg_end_x <= COORD_BITS'(bx);
		seg_end_y <= COORD_BITS'(by);
		point_x <= COORD_BITS'(px);
		point_y <= COORD_BITS'(py);
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		sent++;
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	// random query shaped toward one of several geometric situations
	task automatic send_random();
		int cx, cy, ax, ay, bx, by, t;
		cx = $urandom;
		cy = $urandom;
		ax = cx + $urandom_range(0, 400) - 200;
		ay = cy + $urandom_range(0, 400) - 200;
		bx = cx + $urandom_range(0, 400) - 200;
		by = cy + $urandom_range(0, 400) - 200;
		case ($urandom_range(0, 9))
			0, 1, 2, 3:
				send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			4, 5:
				send_query(ax, ay, bx, by, cx + $urandom_range(0, 600) - 300,
					cy + $urandom_range(0, 600) - 300);
			6:
				send_query(ax, ay, ax, ay, $urandom, $urandom);
			7: begin
				// point on the line through AB, inside or past either end
				t = $urandom_range(0, 6) - 2;
				send_query(ax, ay, bx, by, ax + t * (bx - ax) / 2, ay + t * (by - ay) / 2);
			end
			8:
				send_query(ax, ay, bx, by, ($urandom_range(0, 1) ? ax : bx),
					($urandom_range(0, 1) ? ay : by));
			default:
				send_query(pick_extreme(), pick_extreme(), pick_extreme(),
					pick_extreme(), pick_extreme(), pick_extreme());
		endcase
	endtask

	initial begin
		int wait_cycles;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_query(0, 0, 0, 0, 0, 0);
		send_query(-32768, -32768, -32768, -32768, 32767, 32767);
		send_query(32767, 32767, 32767, 32767, -32768, -32768);
		send_query(-32768, -32768, 32767, 32767, 32767, -32768);
		send_query(-32768, 32767, 32767, -32768, -32768, -32768);
		send_query(-32768, 0, 32767, 0, 0, 32767);
		send_query(0, 0, 10, 0, 5, 3);
		send_query(0, 0, 10, 0, -4, 3);
		send_query(0, 0, 10, 0, 14, -3);
		send_query(0, 0, 10, 0, 0, 7);
		send_query(0, 0, 10, 0, 10, -7);
		send_query(0, 0, 10, 0, 5, 0);
		send_query(0, 0, 10, 0, 20, 0);
		send_query(3, 4, 3, 4, 0, 0);
		send_query(0, 0, 1, 1, 1, 0);
		send_query(0, 0, 3, 3, 0, 1);
		send_query(-1, -1, 1, 1, -1, 1);
		send_query(100, 200, -300, 50, 7, -9);
		send_query(32767, -32768, 32767, 32767, -32768, 0);
		send_query(-1, -1, -1, -1, -1, -1);

		// random traffic with one long hold-off on the output side
		for (int i = 0; i < 560; i++) begin
			if (i == 200)
				hold_go <= 1'b1;
			send_random();
		end
		// final stretch with no idling on either side
		quiet <= 1'b1;
		for (int i = 0; i < 70; i++)
			send_random();
		in_valid <= 1'b0;

		// drain, then let the pipeline settle
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);

		$display("run covered %0d queries and %0d checked results, including",
			sent, checked);
		$display("corner, degenerate, collinear and endpoint cases with output stalls");
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
src/pts_pkg.sv
src/pts_front.sv
src/pts_div.sv
src/pts_sqrt.sv
src/point_to_segment_distance.sv
dv/pts_checker.sv
dv/tb_point_to_segment_distance.sv
